// ----- rtl/core/tbfe_pkg.sv -----
// shared types, register indexes and frame coding for the biphase tape encoder
package tbfe_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_PILOT    = 2'd0;
    localparam logic [1:0] CFG_PAUSE    = 2'd1;
    localparam logic [1:0] CFG_RAW_HDR  = 2'd2;

    // register reset values
    localparam logic [11:0] PILOT_RESET   = 12'd3600;
    localparam logic [10:0] PAUSE_RESET   = 11'd600;
    localparam logic [7:0]  RAW_HDR_RESET = 8'd63;

    // signature bytes
    localparam logic [7:0] SIG_BYTE_A = 8'hFF;
    localparam logic [7:0] SIG_BYTE_B = 8'h00;
    localparam logic [7:0] SIG_BYTE_C = 8'h55;

    localparam logic KIND_RUN   = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } in_beat_t;

    typedef struct packed {
        logic        kind;
        logic [11:0] run_length;
        logic [21:0] halves;
        logic        final_res;
    } out_beat_t;

    typedef struct packed {
        logic [11:0] pilot_bits;
        logic [10:0] pause_bits;
        logic [7:0]  raw_header_bytes;
    } cfg_t;

    typedef enum logic [2:0] {
        PH_DETECT,
        PH_RAW_HDR,
        PH_RAW_DATA,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_WAIT,
        PH_DATA
    } phase_t;

    typedef enum logic [2:0] {
        SQ_TAKE,
        SQ_RUN,
        SQ_SCAN_RD,
        SQ_SCAN_CMP,
        SQ_DECIDE,
        SQ_POP,
        SQ_PAUSE,
        SQ_END
    } seq_t;

    // run of one-bits
    function automatic out_beat_t make_run(input logic [11:0] bits);
        out_beat_t r;
        r.kind       = KIND_RUN;
        r.run_length = bits;
        r.halves     = '0;
        r.final_res  = 1'b0;
        return r;
    endfunction

    // 11-bit frame: start 0, data lsb first, two stops; one = low then high
    function automatic out_beat_t make_frame(input logic [7:0] b);
        out_beat_t   r;
        logic [10:0] bits;
        bits = {2'b11, b, 1'b0};
        r.kind       = KIND_FRAME;
        r.run_length = '0;
        r.final_res  = 1'b0;
        for (int k = 0; k < 11; k++) begin
            r.halves[2*k]   = ~bits[k];
            r.halves[2*k+1] = bits[k];
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/tbfe_front.sv -----
// input queue: two-entry buffer between the input channel and the engine
module tbfe_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tbfe_pkg::in_beat_t s_data,
    output logic               q_valid,
    input  logic               q_ready,
    output tbfe_pkg::in_beat_t q_data
);

    logic [1:0]         cnt_reg, cnt_next;
    tbfe_pkg::in_beat_t d0_reg, d0_next, d1_reg, d1_next;
    logic               push, pop;

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = d0_reg;
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    // shift on pop, write behind the remaining entries on push
    always_comb begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
        d0_next  = pop ? d1_reg : d0_reg;
        d1_next  = d1_reg;
        if (push) begin
            if ((cnt_reg - {1'b0, pop}) == 2'd0) begin
                d0_next = s_data;
            end else begin
                d1_next = s_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
        d0_reg <= d0_next;
        d1_reg <= d1_next;
    end

endmodule

// ----- rtl/core/tbfe_outq.sv -----
// result queue: two-entry buffer in front of the result channel
module tbfe_outq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                p_valid,
    output logic                p_ready,
    input  tbfe_pkg::out_beat_t p_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tbfe_pkg::out_beat_t m_data
);

    logic [1:0]          cnt_reg, cnt_next;
    tbfe_pkg::out_beat_t d0_reg, d0_next, d1_reg, d1_next;
    logic                push, pop;

    assign p_ready = (cnt_reg != 2'd2);
    assign m_valid = (cnt_reg != 2'd0);
    assign m_data  = d0_reg;
    assign push    = p_valid && p_ready;
    assign pop     = m_valid && m_ready;

    // shift on pop, write behind the remaining entries on push
    always_comb begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
        d0_next  = pop ? d1_reg : d0_reg;
        d1_next  = d1_reg;
        if (push) begin
            if ((cnt_reg - {1'b0, pop}) == 2'd0) begin
                d0_next = p_data;
            end else begin
                d1_next = p_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
        d0_reg <= d0_next;
        d1_reg <= d1_next;
    end

endmodule

// ----- rtl/core/tbfe_back.sv -----
// encoding engine: lookahead memory, signature scan and line frame sequencer
module tbfe_back #(
    parameter int LOOKAHEAD_DEPTH = 64,
    parameter int SIGNATURE_RUN   = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  tbfe_pkg::cfg_t      cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  tbfe_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tbfe_pkg::out_beat_t out_data
);

    localparam int SIG_LEN = 3 * SIGNATURE_RUN;
    localparam int AW      = $clog2(LOOKAHEAD_DEPTH);
    localparam int FW      = $clog2(LOOKAHEAD_DEPTH + 1);
    localparam int SW      = $clog2(SIG_LEN);

    logic [7:0]          mem [LOOKAHEAD_DEPTH];
    logic [AW-1:0]       head_reg, head_next;
    logic [FW-1:0]       fill_reg, fill_next;
    tbfe_pkg::phase_t    phase_reg, phase_next;
    tbfe_pkg::seq_t      seq_reg, seq_next;
    logic [7:0]          idx_reg, idx_next;
    logic [15:0]         blk_reg, blk_next;
    logic [7:0]          len_lo_reg, len_lo_next;
    logic                ended_reg, ended_next;
    logic                sig_reg, sig_next;
    logic [SW-1:0]       scan_reg, scan_next;
    logic [7:0]          rd_data_reg;
    tbfe_pkg::out_beat_t pend_reg, pend_next;
    logic                pend_v_reg, pend_v_next;

    logic                mem_we;
    logic [AW:0]         rd_sum;
    logic [AW-1:0]       rd_addr;
    logic [AW+1:0]       wr_sum;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       head_inc;
    logic                can_emit;
    logic                emit;
    tbfe_pkg::out_beat_t emit_data;
    logic                wait_ok;
    logic                fill_sig;
    logic [7:0]          exp_byte;
    logic                finish;

    // circular addressing of the lookahead
    always_comb begin
        rd_sum  = {1'b0, head_reg} + (AW+1)'(scan_reg);
        if (rd_sum >= (AW+1)'(LOOKAHEAD_DEPTH)) begin
            rd_sum = rd_sum - (AW+1)'(LOOKAHEAD_DEPTH);
        end
        rd_addr = rd_sum[AW-1:0];
        wr_sum  = (AW+2)'(head_reg) + (AW+2)'(fill_reg);
        if (wr_sum >= (AW+2)'(LOOKAHEAD_DEPTH)) begin
            wr_sum = wr_sum - (AW+2)'(LOOKAHEAD_DEPTH);
        end
        wr_addr  = wr_sum[AW-1:0];
        head_inc = (head_reg == AW'(LOOKAHEAD_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    end

    // expected signature byte at the scan position
    always_comb begin
        if (scan_reg < SW'(SIGNATURE_RUN)) begin
            exp_byte = tbfe_pkg::SIG_BYTE_A;
        end else if (scan_reg < SW'(2 * SIGNATURE_RUN)) begin
            exp_byte = tbfe_pkg::SIG_BYTE_B;
        end else begin
            exp_byte = tbfe_pkg::SIG_BYTE_C;
        end
    end

    assign fill_sig = (fill_reg >= FW'(SIG_LEN));
    assign wait_ok  = (blk_reg < 16'(SIG_LEN)) ?
                      ({{(16-FW){1'b0}}, fill_reg} >= blk_reg) : fill_sig;
    assign can_emit = !pend_v_reg || out_ready;

    // sequencer: one phase step at a time, one result held back for the final mark
    always_comb begin
        head_next   = head_reg;
        fill_next   = fill_reg;
        phase_next  = phase_reg;
        seq_next    = seq_reg;
        idx_next    = idx_reg;
        blk_next    = blk_reg;
        len_lo_next = len_lo_reg;
        ended_next  = ended_reg;
        sig_next    = sig_reg;
        scan_next   = scan_reg;
        mem_we      = 1'b0;
        in_ready    = 1'b0;
        emit        = 1'b0;
        emit_data   = tbfe_pkg::make_frame(rd_data_reg);
        out_valid   = 1'b0;
        out_data    = pend_reg;
        finish      = 1'b0;

        unique case (seq_reg)
            tbfe_pkg::SQ_TAKE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (fill_reg < FW'(LOOKAHEAD_DEPTH)) begin
                        mem_we    = 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                    ended_next = in_data.last;
                    seq_next   = tbfe_pkg::SQ_RUN;
                end
            end
            tbfe_pkg::SQ_RUN: begin
                unique case (phase_reg)
                    tbfe_pkg::PH_DETECT: begin
                        if (fill_sig) begin
                            sig_next = 1'b1;
                            seq_next = tbfe_pkg::SQ_SCAN_RD;
                        end else if (ended_reg) begin
                            sig_next = 1'b0;
                            seq_next = tbfe_pkg::SQ_DECIDE;
                        end else begin
                            seq_next = tbfe_pkg::SQ_END;
                        end
                    end
                    tbfe_pkg::PH_WAIT: begin
                        if (wait_ok || ended_reg) begin
                            if (blk_reg >= 16'(SIG_LEN) && fill_sig) begin
                                sig_next = 1'b1;
                                seq_next = tbfe_pkg::SQ_SCAN_RD;
                            end else begin
                                sig_next = 1'b0;
                                seq_next = tbfe_pkg::SQ_DECIDE;
                            end
                        end else begin
                            seq_next = tbfe_pkg::SQ_END;
                        end
                    end
                    default: begin
                        seq_next = (fill_reg == '0) ? tbfe_pkg::SQ_END : tbfe_pkg::SQ_POP;
                    end
                endcase
            end
            tbfe_pkg::SQ_SCAN_RD: begin
                seq_next = tbfe_pkg::SQ_SCAN_CMP;
            end
            tbfe_pkg::SQ_SCAN_CMP: begin
                if (rd_data_reg != exp_byte) begin
                    sig_next  = 1'b0;
                    scan_next = '0;
                    seq_next  = tbfe_pkg::SQ_DECIDE;
                end else if (scan_reg == SW'(SIG_LEN - 1)) begin
                    scan_next = '0;
                    seq_next  = tbfe_pkg::SQ_DECIDE;
                end else begin
                    scan_next = scan_reg + 1'b1;
                    seq_next  = tbfe_pkg::SQ_SCAN_RD;
                end
            end
            tbfe_pkg::SQ_DECIDE: begin
                if (can_emit) begin
                    emit     = 1'b1;
                    seq_next = tbfe_pkg::SQ_RUN;
                    if (phase_reg == tbfe_pkg::PH_DETECT) begin
                        emit_data = tbfe_pkg::make_run(cfg.pilot_bits);
                        idx_next  = '0;
                        if (sig_reg) begin
                            phase_next = tbfe_pkg::PH_RAW_HDR;
                            if (cfg.raw_header_bytes == '0) begin
                                phase_next = tbfe_pkg::PH_RAW_DATA;
                                seq_next   = tbfe_pkg::SQ_PAUSE;
                            end
                        end else begin
                            phase_next = tbfe_pkg::PH_LEN_LO;
                        end
                    end else begin
                        emit_data  = tbfe_pkg::make_run(sig_reg ? {cfg.pause_bits, 1'b0}
                                                                : {1'b0, cfg.pause_bits});
                        phase_next = (blk_reg != '0) ? tbfe_pkg::PH_DATA
                                                     : tbfe_pkg::PH_LEN_LO;
                    end
                end
            end
            tbfe_pkg::SQ_POP: begin
                unique case (phase_reg)
                    tbfe_pkg::PH_RAW_HDR: begin
                        if (can_emit) begin
                            emit      = 1'b1;
                            head_next = head_inc;
                            fill_next = fill_reg - 1'b1;
                            idx_next  = idx_reg + 1'b1;
                            if (({1'b0, idx_reg} + 9'd1) >= {1'b0, cfg.raw_header_bytes}) begin
                                phase_next = tbfe_pkg::PH_RAW_DATA;
                                seq_next   = tbfe_pkg::SQ_PAUSE;
                            end else begin
                                seq_next = tbfe_pkg::SQ_RUN;
                            end
                        end
                    end
                    tbfe_pkg::PH_RAW_DATA: begin
                        if (can_emit) begin
                            emit      = 1'b1;
                            head_next = head_inc;
                            fill_next = fill_reg - 1'b1;
                            seq_next  = tbfe_pkg::SQ_RUN;
                        end
                    end
                    tbfe_pkg::PH_LEN_LO: begin
                        len_lo_next = rd_data_reg;
                        head_next   = head_inc;
                        fill_next   = fill_reg - 1'b1;
                        phase_next  = tbfe_pkg::PH_LEN_HI;
                        seq_next    = tbfe_pkg::SQ_RUN;
                    end
                    tbfe_pkg::PH_LEN_HI: begin
                        blk_next   = {rd_data_reg, len_lo_reg};
                        head_next  = head_inc;
                        fill_next  = fill_reg - 1'b1;
                        phase_next = tbfe_pkg::PH_WAIT;
                        seq_next   = tbfe_pkg::SQ_RUN;
                    end
                    tbfe_pkg::PH_DATA: begin
                        if (can_emit) begin
                            emit      = 1'b1;
                            head_next = head_inc;
                            fill_next = fill_reg - 1'b1;
                            blk_next  = blk_reg - 1'b1;
                            if (blk_reg == 16'd1) begin
                                phase_next = tbfe_pkg::PH_LEN_LO;
                            end
                            seq_next = tbfe_pkg::SQ_RUN;
                        end
                    end
                    default: begin
                        seq_next = tbfe_pkg::SQ_RUN;
                    end
                endcase
            end
            tbfe_pkg::SQ_PAUSE: begin
                if (can_emit) begin
                    emit      = 1'b1;
                    emit_data = tbfe_pkg::make_run({1'b0, cfg.pause_bits});
                    seq_next  = tbfe_pkg::SQ_RUN;
                end
            end
            tbfe_pkg::SQ_END: begin
                if (pend_v_reg) begin
                    out_valid          = 1'b1;
                    out_data.final_res = ended_reg;
                    finish             = out_ready;
                end else if (ended_reg) begin
                    out_valid           = 1'b1;
                    out_data            = tbfe_pkg::make_run('0);
                    out_data.final_res  = 1'b1;
                    finish              = out_ready;
                end else begin
                    finish = 1'b1;
                end
            end
            default: begin
                seq_next = tbfe_pkg::SQ_TAKE;
            end
        endcase

        // a new result pushes the held one out
        pend_next   = pend_reg;
        pend_v_next = pend_v_reg;
        if (emit) begin
            out_valid   = pend_v_reg;
            out_data    = pend_reg;
            pend_next   = emit_data;
            pend_v_next = 1'b1;
        end

        // step done: drop held result and clear the stream after the last byte
        if (finish) begin
            pend_v_next = 1'b0;
            seq_next    = tbfe_pkg::SQ_TAKE;
            if (ended_reg) begin
                fill_next   = '0;
                head_next   = '0;
                phase_next  = tbfe_pkg::PH_DETECT;
                idx_next    = '0;
                blk_next    = '0;
                len_lo_next = '0;
            end
        end
    end

    // lookahead memory with registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= in_data.data_byte;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            fill_reg   <= '0;
            phase_reg  <= tbfe_pkg::PH_DETECT;
            seq_reg    <= tbfe_pkg::SQ_TAKE;
            idx_reg    <= '0;
            blk_reg    <= '0;
            len_lo_reg <= '0;
            ended_reg  <= 1'b0;
            sig_reg    <= 1'b0;
            scan_reg   <= '0;
            pend_v_reg <= 1'b0;
        end else begin
            head_reg   <= head_next;
            fill_reg   <= fill_next;
            phase_reg  <= phase_next;
            seq_reg    <= seq_next;
            idx_reg    <= idx_next;
            blk_reg    <= blk_next;
            len_lo_reg <= len_lo_next;
            ended_reg  <= ended_next;
            sig_reg    <= sig_next;
            scan_reg   <= scan_next;
            pend_v_reg <= pend_v_next;
        end
        pend_reg <= pend_next;
    end

endmodule

// ----- rtl/core/tape_biphase_frame_encoder.sv -----
// Biphase tape frame encoder. Each byte of a tape image enters a two-entry input queue and
// then the encoding engine, which holds up to LOOKAHEAD_DEPTH pending bytes and sends line
// frames (one-bit runs and 22-half byte frames) through a two-entry result queue. The
// engine takes no new byte until its sequencer is through with the last one. Whenever
// 3*SIGNATURE_RUN bytes must be checked for the header signature, the engine reads them one
// at a time from its lookahead memory. The last result of an image carries final_res;
// registers are to be written only while the block is idle: the user is bound to this,
// as the block itself does not enforce it.
module tape_biphase_frame_encoder #(
    parameter int LOOKAHEAD_DEPTH = 64,
    parameter int SIGNATURE_RUN   = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tbfe_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tbfe_pkg::out_beat_t m_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [11:0]         cfg_wdata
);

    tbfe_pkg::cfg_t      cfg_reg;
    logic                q_valid, q_ready;
    tbfe_pkg::in_beat_t  q_data;
    logic                p_valid, p_ready;
    tbfe_pkg::out_beat_t p_data;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pilot_bits       <= tbfe_pkg::PILOT_RESET;
            cfg_reg.pause_bits       <= tbfe_pkg::PAUSE_RESET;
            cfg_reg.raw_header_bytes <= tbfe_pkg::RAW_HDR_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                tbfe_pkg::CFG_PILOT:   cfg_reg.pilot_bits       <= cfg_wdata;
                tbfe_pkg::CFG_PAUSE:   cfg_reg.pause_bits       <= cfg_wdata[10:0];
                tbfe_pkg::CFG_RAW_HDR: cfg_reg.raw_header_bytes <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    tbfe_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data)
    );

    tbfe_back #(
        .LOOKAHEAD_DEPTH (LOOKAHEAD_DEPTH),
        .SIGNATURE_RUN   (SIGNATURE_RUN)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_data   (q_data),
        .out_valid (p_valid),
        .out_ready (p_ready),
        .out_data  (p_data)
    );

    tbfe_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .p_valid (p_valid),
        .p_ready (p_ready),
        .p_data  (p_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ----- rtl/core/tbfe_checker.sv -----
// port checker for the biphase tape encoder, bound to the top level
module tbfe_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input tbfe_pkg::out_beat_t m_data
);

    // no result beat right after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat valid right after reset");

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result beat changed");

    // runs carry no half levels, frames carry no run length
    a_kind_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.kind && m_data.run_length == 12'd0) ||
                    (!m_data.kind && m_data.halves == 22'd0))
        else $error("result fields disagree with kind");

    // frame start bit is high then low, last stop bit low then high
    a_frame_edges: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind |-> m_data.halves[1:0] == 2'b01 &&
                                   m_data.halves[21:20] == 2'b10)
        else $error("frame start or stop bit malformed");

    // a frame carries eleven high halves, as many as it has bit cells
    a_frame_cells: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind |-> $countones(m_data.halves) == 11)
        else $error("frame bit cell not biphase");

endmodule

bind tape_biphase_frame_encoder tbfe_checker u_tbfe_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
